// ===== sv/hhrc_pkg.sv =====
// ----------------------------------------------------------------------------
// HSL / HSV to RGB converter package
// Shared types and constants of the colour converter pipeline.
// ----------------------------------------------------------------------------
package hhrc_pkg;

	localparam logic [1:0] MODE_RGB = 2'd0;
	localparam logic [1:0] MODE_HSL = 2'd1;
	localparam logic [1:0] MODE_HSV = 2'd2;

	// Multiple of 360 that moves any signed 16-bit hue into a positive range.
	localparam logic [16:0] HUE_BIAS   = 17'd33120;
	// floor(u / 360) = (u * HUE_RECIP) >> HUE_SHIFT for every 17-bit u.
	localparam logic [16:0] HUE_RECIP  = 17'd93207;
	localparam int          HUE_SHIFT  = 25;
	// floor(w / 625) = (w * SCALE_RECIP) >> SCALE_SHIFT for every 18-bit w.
	localparam logic [18:0] SCALE_RECIP = 19'd429497;
	localparam int          SCALE_SHIFT = 28;

	localparam int CW  = 14;	// chroma and offset, at most 10000
	localparam int C6W = 20;	// the same scaled by 60, at most 600000

	typedef enum logic [1:0] {
		SEL_ZERO = 2'd0,
		SEL_C    = 2'd1,
		SEL_X    = 2'd2
	} sel_t;

	typedef struct packed {
		logic       err;
		logic       rgb;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} meta_t;

	typedef struct packed {
		logic            valid;
		meta_t           meta;
		sel_t            sel_r;
		sel_t            sel_g;
		sel_t            sel_b;
		logic [C6W-1:0]  c60;
		logic [C6W-1:0]  x60;
		logic [C6W-1:0]  m60;
	} front_t;

endpackage

// ===== sv/hhrc_front.sv =====
// ----------------------------------------------------------------------------
// HSL / HSV converter front end
// Checks ranges, wraps the hue and forms chroma, secondary and offset terms.
// ----------------------------------------------------------------------------
module hhrc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [1:0]          command,
	input  logic signed [15:0]  first_value,
	input  logic [9:0]          second_value,
	input  logic [9:0]          third_value,
	output hhrc_pkg::front_t    front
);

	logic                     valid_s1, valid_s2, valid_s3;
	hhrc_pkg::meta_t          meta_s1, meta_s2, meta_s3;
	logic                     hsl_s1;
	logic [16:0]              u_s1;
	logic [15:0]              u_s2;
	logic [7:0]               q_s1;
	logic [hhrc_pkg::CW-1:0]  c_s1, c_s2;
	logic [hhrc_pkg::CW-1:0]  base_s1;
	logic [hhrc_pkg::CW-1:0]  m_s2;
	hhrc_pkg::sel_t           sel_r_s3, sel_g_s3, sel_b_s3;
	logic [hhrc_pkg::C6W-1:0] c60_s3, x60_s3, m60_s3;

	logic                     err;
	logic                     rgb;
	logic [16:0]              usum;
	logic [33:0]              hprod;
	logic [9:0]               dl;
	logic [9:0]               a;
	logic [16:0]              q360;
	logic [16:0]              hdiff;
	logic [8:0]               hue;
	logic [8:0]               t;
	logic [5:0]               ramp;
	logic [2:0]               sector;
	hhrc_pkg::sel_t           sel_r, sel_g, sel_b;

	always_comb begin
		rgb = (command == hhrc_pkg::MODE_RGB);
		case (command)
			hhrc_pkg::MODE_RGB: begin
				err = first_value[15] || (first_value > 16'sd255) ||
					(second_value > 10'd255) || (third_value > 10'd255);
			end
			hhrc_pkg::MODE_HSL, hhrc_pkg::MODE_HSV: begin
				err = (second_value > 10'd100) || (third_value > 10'd100);
			end
			default: begin
				err = 1'b1;
			end
		endcase
		usum  = {first_value[15], first_value} + hhrc_pkg::HUE_BIAS;
		hprod = {17'd0, usum} * {17'd0, hhrc_pkg::HUE_RECIP};
		if (third_value >= 10'd50) begin
			dl = third_value - 10'd50;
		end else begin
			dl = 10'd50 - third_value;
		end
		if (command == hhrc_pkg::MODE_HSL) begin
			a = 10'd100 - {dl[8:0], 1'b0};
		end else begin
			a = third_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1.err <= err;
			meta_s1.rgb <= rgb;
			meta_s1.r   <= first_value[7:0];
			meta_s1.g   <= second_value[7:0];
			meta_s1.b   <= third_value[7:0];
			hsl_s1      <= (command == hhrc_pkg::MODE_HSL);
			u_s1        <= usum;
			q_s1        <= hprod[hhrc_pkg::HUE_SHIFT+7:hhrc_pkg::HUE_SHIFT];
			c_s1        <= {7'd0, a[6:0]} * {7'd0, second_value[6:0]};
			base_s1     <= {7'd0, third_value[6:0]} * 14'd100;
		end
	end

	always_comb begin
		q360 = {9'd0, q_s1} * 17'd360;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s2 <= meta_s1;
			u_s2    <= 16'(u_s1 - q360);
			c_s2    <= c_s1;
			if (hsl_s1) begin
				m_s2 <= base_s1 - {1'b0, c_s1[hhrc_pkg::CW-1:1]};
			end else begin
				m_s2 <= base_s1 - c_s1;
			end
		end
	end

	always_comb begin
		hdiff = {1'b0, u_s2};
		hue   = hdiff[8:0];
		if (hue < 9'd60) begin
			sector = 3'd0;
		end else if (hue < 9'd120) begin
			sector = 3'd1;
		end else if (hue < 9'd180) begin
			sector = 3'd2;
		end else if (hue < 9'd240) begin
			sector = 3'd3;
		end else if (hue < 9'd300) begin
			sector = 3'd4;
		end else begin
			sector = 3'd5;
		end
		if (hue < 9'd120) begin
			t = hue;
		end else if (hue < 9'd240) begin
			t = hue - 9'd120;
		end else begin
			t = hue - 9'd240;
		end
		if (t < 9'd60) begin
			ramp = t[5:0];
		end else begin
			ramp = 6'(9'd120 - t);
		end
		case (sector)
			3'd0: begin
				sel_r = hhrc_pkg::SEL_C;    sel_g = hhrc_pkg::SEL_X;    sel_b = hhrc_pkg::SEL_ZERO;
			end
			3'd1: begin
				sel_r = hhrc_pkg::SEL_X;    sel_g = hhrc_pkg::SEL_C;    sel_b = hhrc_pkg::SEL_ZERO;
			end
			3'd2: begin
				sel_r = hhrc_pkg::SEL_ZERO; sel_g = hhrc_pkg::SEL_C;    sel_b = hhrc_pkg::SEL_X;
			end
			3'd3: begin
				sel_r = hhrc_pkg::SEL_ZERO; sel_g = hhrc_pkg::SEL_X;    sel_b = hhrc_pkg::SEL_C;
			end
			3'd4: begin
				sel_r = hhrc_pkg::SEL_X;    sel_g = hhrc_pkg::SEL_ZERO; sel_b = hhrc_pkg::SEL_C;
			end
			default: begin
				sel_r = hhrc_pkg::SEL_C;    sel_g = hhrc_pkg::SEL_ZERO; sel_b = hhrc_pkg::SEL_X;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s3  <= meta_s2;
			sel_r_s3 <= sel_r;
			sel_g_s3 <= sel_g;
			sel_b_s3 <= sel_b;
			c60_s3   <= {6'd0, c_s2} * 20'd60;
			x60_s3   <= {6'd0, c_s2} * {14'd0, ramp};
			m60_s3   <= {6'd0, m_s2} * 20'd60;
		end
	end

	always_comb begin
		front.valid = valid_s3;
		front.meta  = meta_s3;
		front.sel_r = sel_r_s3;
		front.sel_g = sel_g_s3;
		front.sel_b = sel_b_s3;
		front.c60   = c60_s3;
		front.x60   = x60_s3;
		front.m60   = m60_s3;
	end

`ifndef SYNTHESIS
	a_one_chroma: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> $countones({sel_r_s3 == hhrc_pkg::SEL_C, sel_g_s3 == hhrc_pkg::SEL_C,
			sel_b_s3 == hhrc_pkg::SEL_C}) == 1)
		else $error("front end selects chroma for other than one channel");
`endif

endmodule

// ===== sv/hhrc_chan.sv =====
// ----------------------------------------------------------------------------
// HSL / HSV converter channel scaler
// Adds the offset to the selected term and scales the sum to an 8-bit level.
// ----------------------------------------------------------------------------
module hhrc_chan (
	input  logic                      clk,
	input  logic                      en,
	input  hhrc_pkg::sel_t            sel,
	input  logic [hhrc_pkg::C6W-1:0]  c60,
	input  logic [hhrc_pkg::C6W-1:0]  x60,
	input  logic [hhrc_pkg::C6W-1:0]  m60,
	output logic [7:0]                level
);

	logic [23:0] n_s4;
	logic [8:0]  q_s5;
	logic [20:0] v;
	logic [20:0] term;
	logic [17:0] w;
	logic [36:0] prod;

	always_comb begin
		case (sel)
			hhrc_pkg::SEL_C: begin
				term = {1'b0, c60};
			end
			hhrc_pkg::SEL_X: begin
				term = {1'b0, x60};
			end
			default: begin
				term = 21'd0;
			end
		endcase
		v = term + {1'b0, m60};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s4 <= 24'({3'd0, v} * 24'd17);
		end
	end

	always_comb begin
		w    = n_s4[23:6];
		prod = {19'd0, w} * {18'd0, hhrc_pkg::SCALE_RECIP};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s5 <= prod[hhrc_pkg::SCALE_SHIFT+8:hhrc_pkg::SCALE_SHIFT];
		end
	end

	assign level = q_s5[8] ? 8'd255 : q_s5[7:0];

endmodule

// ===== sv/hsl_hsv_to_rgb_converter_top.sv =====
// ----------------------------------------------------------------------------
// HSL / HSV to RGB converter
// Converts one colour word per clock, unless stalled, from RGB, HSL or HSV into RGB levels.
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------------
//   input   | in_valid / in_stall   | command, first_value, second_value,
//           |                       | third_value
//   output  | out_valid / out_stall | red, green, blue, range_fault
//
// A word passes six register stages, from the stage that accepts it to the
// output register; one word may enter every cycle unless the output stalls. The
// pipeline depth is set by the hue division and the final reciprocal scaling, each
// split over two multiplier stages. Reset clears only the valid bits. A stall
// at the output while out_valid is high freezes every stage and is passed back
// to in_stall in the same cycle.
// ----------------------------------------------------------------------------
module hsl_hsv_to_rgb_converter_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic signed [15:0] first_value,
	input  logic [9:0]         second_value,
	input  logic [9:0]         third_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic               range_fault
);

	logic             en;
	hhrc_pkg::front_t front;
	logic             valid_s4, valid_s5, valid_s6;
	hhrc_pkg::meta_t  meta_s4, meta_s5;
	logic [7:0]       lvl_r, lvl_g, lvl_b;
	logic [7:0]       red_s6, green_s6, blue_s6;
	logic             err_s6;

	assign en       = !(valid_s6 && out_stall);
	assign in_stall = !en;

	hhrc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (in_valid),
		.command      (command),
		.first_value  (first_value),
		.second_value (second_value),
		.third_value  (third_value),
		.front        (front)
	);

	hhrc_chan u_chan_r (
		.clk   (clk),
		.en    (en),
		.sel   (front.sel_r),
		.c60   (front.c60),
		.x60   (front.x60),
		.m60   (front.m60),
		.level (lvl_r)
	);

	hhrc_chan u_chan_g (
		.clk   (clk),
		.en    (en),
		.sel   (front.sel_g),
		.c60   (front.c60),
		.x60   (front.x60),
		.m60   (front.m60),
		.level (lvl_g)
	);

	hhrc_chan u_chan_b (
		.clk   (clk),
		.en    (en),
		.sel   (front.sel_b),
		.c60   (front.c60),
		.x60   (front.x60),
		.m60   (front.m60),
		.level (lvl_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s4 <= front.valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s4 <= front.meta;
			meta_s5 <= meta_s4;
			err_s6  <= meta_s5.err;
			if (meta_s5.err) begin
				red_s6   <= 8'd0;
				green_s6 <= 8'd0;
				blue_s6  <= 8'd0;
			end else if (meta_s5.rgb) begin
				red_s6   <= meta_s5.r;
				green_s6 <= meta_s5.g;
				blue_s6  <= meta_s5.b;
			end else begin
				red_s6   <= lvl_r;
				green_s6 <= lvl_g;
				blue_s6  <= lvl_b;
			end
		end
	end

	assign out_valid   = valid_s6;
	assign red         = red_s6;
	assign green       = green_s6;
	assign blue        = blue_s6;
	assign range_fault = err_s6;

`ifndef SYNTHESIS
	a_err_black: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && err_s6 |-> red_s6 == 8'd0 && green_s6 == 8'd0 && blue_s6 == 8'd0)
		else $error("error word carries a non-zero colour");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && en |=> valid_s6)
		else $error("word lost between last two stages");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s4) && $stable(valid_s5) && $stable(front.valid))
		else $error("pipeline moved while the output was stalled");
`endif

endmodule

// ===== tb/sv/tb_hsl_hsv_to_rgb_converter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the HSL / HSV to RGB converter
// A short table of hand-picked colour words runs first: RGB limits, hue wrap,
// percent limits and the unused mode. Random words follow, mostly well-formed
// HSL, HSV and RGB colours with some raw noise mixed in. Both handshakes idle
// at random, with calm stretches in between. Every result word is checked
// against an integer model of the conversion or against a typed-in value.
// ----------------------------------------------------------------------------
module tb_hsl_hsv_to_rgb_converter_top;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1950;
	localparam int CYCLE_LIMIT = 200000;
	localparam longint LEVEL_SCALE = 600000;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [15:0] first_value;
		logic [9:0]         second_value;
		logic [9:0]         third_value;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       range_fault;
	} rgb_t;

	typedef struct packed {
		pixel_t px;
		logic   typed;
		rgb_t   want;
	} probe_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         command;
	logic signed [15:0] first_value;
	logic [9:0]         second_value;
	logic [9:0]         third_value;
	logic               out_valid;
	logic               out_stall;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic               range_fault;

	rgb_t   expected_rgb[$];
	probe_t probe_table[$];
	int     failures;
	int     cycles;
	int     hold_left;
	logic   calm;
	rgb_t   got_rgb;
	rgb_t   want_rgb;

	hsl_hsv_to_rgb_converter_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.first_value (first_value),
		.second_value(second_value),
		.third_value (third_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.range_fault (range_fault)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] level_of(longint v60);
		longint q;
		q = (v60 < 0) ? 0 : (v60 * 255) / LEVEL_SCALE;
		if (q > 255)
			q = 255;
		return q[7:0];
	endfunction

	function automatic rgb_t predict_rgb(pixel_t px);
		rgb_t   res;
		int     first, sat, lev, hue, dt, ramp, dl;
		longint c, m, c60, x60, m60, rr, gg, bb;
		res = '0;
		first = px.first_value;
		sat = px.second_value;
		lev = px.third_value;
		case (px.command)
			hhrc_pkg::MODE_RGB: begin
				if (first < 0 || first > 255 || sat > 255 || lev > 255) begin
					res.range_fault = 1'b1;
				end else begin
					res.red = first[7:0];
					res.green = sat[7:0];
					res.blue = lev[7:0];
				end
			end
			hhrc_pkg::MODE_HSL, hhrc_pkg::MODE_HSV: begin
				if (sat > 100 || lev > 100) begin
					res.range_fault = 1'b1;
				end else begin
					hue = ((first % 360) + 360) % 360;
					dt = (hue % 120) - 60;
					if (dt < 0)
						dt = -dt;
					ramp = 60 - dt;
					if (px.command == hhrc_pkg::MODE_HSL) begin
						dl = lev - 50;
						if (dl < 0)
							dl = -dl;
						c = 2 * (50 - dl) * sat;
						m = lev * 100 - c / 2;
					end else begin
						c = lev * sat;
						m = lev * 100 - c;
					end
					c60 = c * 60;
					x60 = c * ramp;
					m60 = m * 60;
					rr = 0;
					gg = 0;
					bb = 0;
					case (hue / 60)
						0: begin rr = c60; gg = x60; end
						1: begin rr = x60; gg = c60; end
						2: begin gg = c60; bb = x60; end
						3: begin gg = x60; bb = c60; end
						4: begin rr = x60; bb = c60; end
						default: begin rr = c60; bb = x60; end
					endcase
					res.red = level_of(rr + m60);
					res.green = level_of(gg + m60);
					res.blue = level_of(bb + m60);
				end
			end
			default: res.range_fault = 1'b1;
		endcase
		return res;
	endfunction

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("%s", msg);
	endtask

	task automatic add_probe(input logic [1:0] cmd, input int first, input int sec,
			input int third, input logic typed, input int r, input int g, input int b,
			input logic err);
		probe_t row;
		row.px.command = cmd;
		row.px.first_value = first[15:0];
		row.px.second_value = sec[9:0];
		row.px.third_value = third[9:0];
		row.typed = typed;
		row.want.red = r[7:0];
		row.want.green = g[7:0];
		row.want.blue = b[7:0];
		row.want.range_fault = err;
		probe_table.push_back(row);
	endtask

	task automatic send_pixel(input pixel_t px, input rgb_t want);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= px.command;
		first_value <= px.first_value;
		second_value <= px.second_value;
		third_value <= px.third_value;
		do @(posedge clk); while (in_stall);
		expected_rgb.push_back(want);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			got_rgb = {red, green, blue, range_fault};
			if (expected_rgb.size() == 0) begin
				note_failure($sformatf("Unexpected word: r=%0d g=%0d b=%0d err=%0b",
					red, green, blue, range_fault));
			end else begin
				want_rgb = expected_rgb.pop_front();
				if (got_rgb !== want_rgb)
					note_failure($sformatf(
						"Mismatch: expected r=%0d g=%0d b=%0d err=%0b, got r=%0d g=%0d b=%0d err=%0b",
						want_rgb.red, want_rgb.green, want_rgb.blue, want_rgb.range_fault,
						got_rgb.red, got_rgb.green, got_rgb.blue, got_rgb.range_fault));
			end
			hold_left = calm ? 0 : $urandom_range(0, 4);
		end else if (hold_left > 0) begin
			hold_left--;
		end
		out_stall <= (hold_left > 0);
	end

	initial begin
		pixel_t      px;
		rgb_t        want;
		logic [31:0] noise;
		int          kind;
		failures = 0;
		cycles = 0;
		hold_left = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		command = hhrc_pkg::MODE_RGB;
		first_value = '0;
		second_value = '0;
		third_value = '0;

		add_probe(hhrc_pkg::MODE_RGB, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0);
		add_probe(hhrc_pkg::MODE_RGB, 255, 255, 255, 1'b1, 255, 255, 255, 1'b0);
		add_probe(hhrc_pkg::MODE_RGB, -1, 0, 0, 1'b1, 0, 0, 0, 1'b1);
		add_probe(hhrc_pkg::MODE_RGB, 256, 10, 20, 1'b1, 0, 0, 0, 1'b1);
		add_probe(hhrc_pkg::MODE_RGB, 0, 1023, 0, 1'b1, 0, 0, 0, 1'b1);
		add_probe(hhrc_pkg::MODE_RGB, 0, 0, 1023, 1'b1, 0, 0, 0, 1'b1);
		add_probe(hhrc_pkg::MODE_RGB, -32768, 0, 0, 1'b1, 0, 0, 0, 1'b1);
		add_probe(hhrc_pkg::MODE_RGB, 32767, 0, 0, 1'b1, 0, 0, 0, 1'b1);
		add_probe(hhrc_pkg::MODE_HSL, 0, 100, 50, 1'b1, 255, 0, 0, 1'b0);
		add_probe(hhrc_pkg::MODE_HSV, 120, 100, 100, 1'b1, 0, 255, 0, 1'b0);
		add_probe(hhrc_pkg::MODE_HSV, 240, 100, 100, 1'b1, 0, 0, 255, 1'b0);
		add_probe(hhrc_pkg::MODE_HSL, 0, 0, 100, 1'b1, 255, 255, 255, 1'b0);
		add_probe(hhrc_pkg::MODE_HSV, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0);
		add_probe(hhrc_pkg::MODE_HSL, 30, 101, 50, 1'b1, 0, 0, 0, 1'b1);
		add_probe(hhrc_pkg::MODE_HSV, 30, 50, 101, 1'b1, 0, 0, 0, 1'b1);
		add_probe(hhrc_pkg::MODE_HSL, 30, 1023, 1023, 1'b1, 0, 0, 0, 1'b1);
		add_probe(MODE_UNUSED, 100, 50, 50, 1'b1, 0, 0, 0, 1'b1);
		add_probe(hhrc_pkg::MODE_HSL, -1, 50, 50, 1'b0, 0, 0, 0, 1'b0);
		add_probe(hhrc_pkg::MODE_HSL, -32768, 100, 40, 1'b0, 0, 0, 0, 1'b0);
		add_probe(hhrc_pkg::MODE_HSL, -32761, 100, 40, 1'b0, 0, 0, 0, 1'b0);
		add_probe(hhrc_pkg::MODE_HSV, 32767, 80, 90, 1'b0, 0, 0, 0, 1'b0);
		add_probe(hhrc_pkg::MODE_HSV, 60, 100, 100, 1'b0, 0, 0, 0, 1'b0);
		add_probe(hhrc_pkg::MODE_HSL, 300, 75, 25, 1'b0, 0, 0, 0, 1'b0);
		add_probe(hhrc_pkg::MODE_HSV, 359, 100, 100, 1'b0, 0, 0, 0, 1'b0);
		add_probe(hhrc_pkg::MODE_HSL, 180, 37, 63, 1'b0, 0, 0, 0, 1'b0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probe_table[i]) begin
			want = probe_table[i].typed ? probe_table[i].want : predict_rgb(probe_table[i].px);
			send_pixel(probe_table[i].px, want);
		end

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			calm = ((n / 150) % 3 == 2);
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				noise = $urandom;
				px.command = noise[1:0];
				px.first_value = noise[31:16];
				noise = $urandom;
				px.second_value = noise[9:0];
				px.third_value = noise[25:16];
			end else if (kind < 30) begin
				px.command = hhrc_pkg::MODE_RGB;
				noise = $urandom_range(0, 255);
				px.first_value = noise[15:0];
				noise = $urandom_range(0, 255);
				px.second_value = noise[9:0];
				noise = $urandom_range(0, 255);
				px.third_value = noise[9:0];
			end else begin
				px.command = ($urandom_range(0, 1) == 0) ? hhrc_pkg::MODE_HSL : hhrc_pkg::MODE_HSV;
				noise = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 359);
				px.first_value = noise[15:0];
				noise = $urandom_range(0, 100);
				px.second_value = noise[9:0];
				noise = $urandom_range(0, 100);
				px.third_value = noise[9:0];
			end
			send_pixel(px, predict_rgb(px));
		end
		in_valid <= 1'b0;

		while (expected_rgb.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
